>>> hw/rtl/sacdt_pkg.sv
package sacdt_pkg;

    localparam int NUM_W      = 37;
    localparam int MAG_W      = 36;
    localparam int DEN_W      = 56;
    localparam int DMAG_W     = 55;
    localparam int REM_W      = 57;
    localparam int QUO_W      = 32;
    localparam int TIME_W     = 34;
    localparam int DIV_STAGES = QUO_W + 1;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int IN_W       = 344;
    localparam int OUT_W      = 24;

    localparam logic signed [NUM_W-1:0]  SHRINK2   = NUM_W'(1311);
    localparam logic signed [TIME_W-1:0] T_MAX     = 34'sh0_7FFF_FFFF;
    localparam logic signed [TIME_W-1:0] T_MIN     = -34'sh0_8000_0000;
    localparam logic signed [TIME_W-1:0] T_UNB     = 34'sh1_0000_0000;
    localparam logic signed [TIME_W-1:0] T_NEG_UNB = -34'sh1_0000_0000;
    localparam logic signed [TIME_W-1:0] T_ONE     = 34'sh0_0001_0000;

    typedef struct packed {
        logic [MAG_W-1:0]  lo_mag;
        logic [MAG_W-1:0]  hi_mag;
        logic [DMAG_W-1:0] den_mag;
        logic              lo_neg;
        logic              hi_neg;
        logic              den_neg;
        logic              den_zero;
        logic              miss;
        logic              vel_neg;
    } t_axis;

    typedef struct packed {
        t_axis x;
        t_axis y;
        logic  active;
    } t_job;

    typedef struct packed {
        logic lo_neg;
        logic hi_neg;
        logic den_neg;
        logic den_zero;
        logic miss;
        logic vel_neg;
    } t_side_axis;

    typedef struct packed {
        t_side_axis x;
        t_side_axis y;
        logic       active;
    } t_side;

endpackage

>>> hw/rtl/sacdt_front.sv
module sacdt_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [sacdt_pkg::IN_W-1:0] i_data,
    output logic                    o_valid,
    input  logic                    i_ready,
    output sacdt_pkg::t_job         o_job
);

    localparam int NW = sacdt_pkg::NUM_W;
    localparam int DW = sacdt_pkg::DEN_W;

    logic [31:0] mpx, mpy, vx, vy, tpx, tpy;
    logic [30:0] mw, mh, tw, th;
    logic        act;
    logic [23:0] ft;

    assign mpx = i_data[31:0];
    assign mpy = i_data[63:32];
    assign mw  = i_data[94:64];
    assign mh  = i_data[125:95];
    assign vx  = i_data[157:126];
    assign vy  = i_data[189:158];
    assign tpx = i_data[221:190];
    assign tpy = i_data[253:222];
    assign tw  = i_data[284:254];
    assign th  = i_data[315:285];
    assign act = i_data[316];
    assign ft  = i_data[340:317];

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    logic signed [NW-1:0] px2, py2, tx2, ty2, wx, wy;
    logic signed [NW-1:0] n_lo_x, n_hi_x, n_lo_y, n_hi_y;
    logic signed [DW-1:0] vx_e, vy_e, ft_e, n_den_x, n_den_y;

    always_comb begin
        px2 = NW'($signed({mpx, 1'b0}));
        py2 = NW'($signed({mpy, 1'b0}));
        tx2 = NW'($signed({tpx, 1'b0}));
        ty2 = NW'($signed({tpy, 1'b0}));
        wx  = $signed({6'b0, tw}) + $signed({6'b0, mw});
        wy  = $signed({6'b0, th}) + $signed({6'b0, mh});
        n_lo_x = tx2 - wx + sacdt_pkg::SHRINK2 - px2;
        n_hi_x = tx2 + wx - sacdt_pkg::SHRINK2 - px2;
        n_lo_y = ty2 - wy + sacdt_pkg::SHRINK2 - py2;
        n_hi_y = ty2 + wy - sacdt_pkg::SHRINK2 - py2;
        vx_e = DW'($signed(vx));
        vy_e = DW'($signed(vy));
        ft_e = DW'($signed({1'b0, ft}));
        n_den_x = vx_e * ft_e;
        n_den_y = vy_e * ft_e;
    end

    logic                 r_v1;
    logic signed [NW-1:0] r_lo_x, r_hi_x, r_lo_y, r_hi_y;
    logic signed [DW-1:0] r_den_x, r_den_y;
    logic                 r_vxn, r_vyn, r_act;
    logic                 r_v2;
    sacdt_pkg::t_job      r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lo_x  <= n_lo_x;
            r_hi_x  <= n_hi_x;
            r_lo_y  <= n_lo_y;
            r_hi_y  <= n_hi_y;
            r_den_x <= n_den_x;
            r_den_y <= n_den_y;
            r_vxn   <= vx[31];
            r_vyn   <= vy[31];
            r_act   <= act;
        end
    end

    function automatic sacdt_pkg::t_axis f_axis(input logic signed [NW-1:0] lo,
                                                input logic signed [NW-1:0] hi,
                                                input logic signed [DW-1:0] den,
                                                input logic vneg);
        sacdt_pkg::t_axis a;
        logic signed [NW-1:0] lo_abs, hi_abs;
        logic signed [DW-1:0] den_abs;
        begin
            lo_abs  = lo[NW-1] ? -lo : lo;
            hi_abs  = hi[NW-1] ? -hi : hi;
            den_abs = den[DW-1] ? -den : den;
            a.lo_mag   = lo_abs[sacdt_pkg::MAG_W-1:0];
            a.hi_mag   = hi_abs[sacdt_pkg::MAG_W-1:0];
            a.den_mag  = den_abs[sacdt_pkg::DMAG_W-1:0];
            a.lo_neg   = lo[NW-1];
            a.hi_neg   = hi[NW-1];
            a.den_neg  = den[DW-1];
            a.den_zero = (den == '0);
            a.miss     = a.den_zero && (!lo[NW-1] || hi[NW-1] || hi == '0);
            a.vel_neg  = vneg;
            f_axis = a;
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_job.x      <= f_axis(r_lo_x, r_hi_x, r_den_x, r_vxn);
            r_job.y      <= f_axis(r_lo_y, r_hi_y, r_den_y, r_vyn);
            r_job.active <= r_act;
        end
    end

    assign o_valid = r_v2;
    assign o_job   = r_job;

endmodule

>>> hw/rtl/sacdt_fifo.sv
module sacdt_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  sacdt_pkg::t_job i_job,
    output logic            o_valid,
    input  logic            i_ready,
    output sacdt_pkg::t_job o_job
);

    localparam int AW = sacdt_pkg::FIFO_AW;

    sacdt_pkg::t_job r_mem [sacdt_pkg::FIFO_DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;
    logic            push, pop;

    assign o_ready = (r_cnt != (AW+1)'(sacdt_pkg::FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop) r_rp <= r_rp + 1'b1;
            if (push && !pop) r_cnt <= r_cnt + 1'b1;
            else if (pop && !push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_job;
    end

endmodule

>>> hw/rtl/sacdt_div.sv
module sacdt_div (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [sacdt_pkg::MAG_W-1:0]    i_num,
    input  logic [sacdt_pkg::DMAG_W-1:0]   i_den,
    output logic [sacdt_pkg::QUO_W-1:0]    o_quo,
    output logic                           o_ovf
);

    localparam int RW = sacdt_pkg::REM_W;
    localparam int QW = sacdt_pkg::QUO_W;
    localparam int NS = sacdt_pkg::DIV_STAGES;

    logic [RW-1:0] r_rem [NS];
    logic [RW-1:0] r_den [NS];
    logic [QW-1:0] r_quo [NS];
    logic          r_ovf [NS];

    // quotient saturates when num >= 2 * den
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= RW'(i_num);
            r_den[0] <= RW'(i_den);
            r_quo[0] <= '0;
            r_ovf[0] <= RW'(i_num) >= {RW'(i_den), 1'b0};
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [RW-1:0] t;
        logic          ge;
        assign t  = (k == 0) ? r_rem[k] : {r_rem[k][RW-2:0], 1'b0};
        assign ge = t >= r_den[k];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= ge ? t - r_den[k] : t;
                r_den[k+1] <= r_den[k];
                r_quo[k+1] <= {r_quo[k][QW-2:0], ge};
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    assign o_quo = r_quo[NS-1];
    assign o_ovf = r_ovf[NS-1];

endmodule

>>> hw/rtl/sacdt_back.sv
module sacdt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  sacdt_pkg::t_job i_job,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_hit,
    output logic [15:0]     o_hit_time,
    output logic [1:0]      o_normal_x,
    output logic [1:0]      o_normal_y
);

    localparam int NS = sacdt_pkg::DIV_STAGES;
    localparam int QW = sacdt_pkg::QUO_W;
    localparam int TW = sacdt_pkg::TIME_W;

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    logic [QW-1:0] q_lx, q_hx, q_ly, q_hy;
    logic          v_lx, v_hx, v_ly, v_hy;

    sacdt_div u_div_lx (.i_clk, .i_en(en), .i_num(i_job.x.lo_mag), .i_den(i_job.x.den_mag),
                        .o_quo(q_lx), .o_ovf(v_lx));
    sacdt_div u_div_hx (.i_clk, .i_en(en), .i_num(i_job.x.hi_mag), .i_den(i_job.x.den_mag),
                        .o_quo(q_hx), .o_ovf(v_hx));
    sacdt_div u_div_ly (.i_clk, .i_en(en), .i_num(i_job.y.lo_mag), .i_den(i_job.y.den_mag),
                        .o_quo(q_ly), .o_ovf(v_ly));
    sacdt_div u_div_hy (.i_clk, .i_en(en), .i_num(i_job.y.hi_mag), .i_den(i_job.y.den_mag),
                        .o_quo(q_hy), .o_ovf(v_hy));

    sacdt_pkg::t_side side_in;
    assign side_in.x      = '{i_job.x.lo_neg, i_job.x.hi_neg, i_job.x.den_neg,
                              i_job.x.den_zero, i_job.x.miss, i_job.x.vel_neg};
    assign side_in.y      = '{i_job.y.lo_neg, i_job.y.hi_neg, i_job.y.den_neg,
                              i_job.y.den_zero, i_job.y.miss, i_job.y.vel_neg};
    assign side_in.active = i_job.active;

    logic             r_vs   [NS];
    sacdt_pkg::t_side r_side [NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_vs[k] <= 1'b0;
        end else if (en) begin
            r_vs[0] <= i_valid;
            for (int k = 1; k < NS; k++) r_vs[k] <= r_vs[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= side_in;
            for (int k = 1; k < NS; k++) r_side[k] <= r_side[k-1];
        end
    end

    function automatic logic signed [TW-1:0] f_sat(input logic [QW-1:0] q,
                                                   input logic ovf,
                                                   input logic neg);
        logic signed [TW-1:0] v;
        begin
            if (ovf) v = neg ? sacdt_pkg::T_MIN : sacdt_pkg::T_MAX;
            else if (neg) v = (q > 32'h8000_0000) ? sacdt_pkg::T_MIN : -$signed({2'b0, q});
            else v = q[QW-1] ? sacdt_pkg::T_MAX : $signed({2'b0, q});
            f_sat = v;
        end
    endfunction

    sacdt_pkg::t_side sd;
    assign sd = r_side[NS-1];

    logic signed [TW-1:0] ta_x, tb_x, ta_y, tb_y;
    logic signed [TW-1:0] n_x1, n_x2, n_y1, n_y2;

    always_comb begin
        ta_x = f_sat(q_lx, v_lx, sd.x.lo_neg ^ sd.x.den_neg);
        tb_x = f_sat(q_hx, v_hx, sd.x.hi_neg ^ sd.x.den_neg);
        ta_y = f_sat(q_ly, v_ly, sd.y.lo_neg ^ sd.y.den_neg);
        tb_y = f_sat(q_hy, v_hy, sd.y.hi_neg ^ sd.y.den_neg);
        if (sd.x.den_zero) begin
            n_x1 = sacdt_pkg::T_NEG_UNB;
            n_x2 = sacdt_pkg::T_UNB;
        end else begin
            n_x1 = (ta_x < tb_x) ? ta_x : tb_x;
            n_x2 = (ta_x < tb_x) ? tb_x : ta_x;
        end
        if (sd.y.den_zero) begin
            n_y1 = sacdt_pkg::T_NEG_UNB;
            n_y2 = sacdt_pkg::T_UNB;
        end else begin
            n_y1 = (ta_y < tb_y) ? ta_y : tb_y;
            n_y2 = (ta_y < tb_y) ? tb_y : ta_y;
        end
    end

    logic                 r_v1, r_skip, r_vxn, r_vyn;
    logic signed [TW-1:0] r_x1, r_x2, r_y1, r_y2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= r_vs[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x1   <= n_x1;
            r_x2   <= n_x2;
            r_y1   <= n_y1;
            r_y2   <= n_y2;
            r_skip <= !sd.active || sd.x.miss || sd.y.miss;
            r_vxn  <= sd.x.vel_neg;
            r_vyn  <= sd.y.vel_neg;
        end
    end

    logic signed [TW-1:0] c1, c2;
    logic                 hit;
    logic [1:0]           nx, ny;

    always_comb begin
        c1  = (r_x1 > r_y1) ? r_x1 : r_y1;
        c2  = (r_x2 < r_y2) ? r_x2 : r_y2;
        hit = !r_skip && !(r_x1 > r_y2) && !(r_y1 > r_x2) && !c1[TW-1]
              && (c1 < sacdt_pkg::T_ONE) && !c2[TW-1];
        nx  = 2'b00;
        ny  = 2'b00;
        if (r_x1 > r_y1) nx = r_vxn ? 2'b01 : 2'b11;
        else if (r_x1 < r_y1) ny = r_vyn ? 2'b01 : 2'b11;
    end

    logic        r_vo, r_hit;
    logic [15:0] r_time;
    logic [1:0]  r_nx, r_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (en) begin
            r_vo <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit  <= hit;
            r_time <= hit ? c1[15:0] : 16'h0;
            r_nx   <= hit ? nx : 2'b00;
            r_ny   <= hit ? ny : 2'b00;
        end
    end

    assign o_valid    = r_vo;
    assign o_hit      = r_hit;
    assign o_hit_time = r_time;
    assign o_normal_x = r_nx;
    assign o_normal_y = r_ny;

endmodule

>>> hw/rtl/swept_aabb_collision_time.sv
// pipeline from input transaction to result: 2 front stages, 1 queue stage,
// 33 divider stages, 2 result stages
// throughput: one transaction per cycle when not stalled (pipelined restoring dividers)
// a 4-entry queue separates front and back so each side stalls on its own
// reset: synchronous active-low i_rst_n clears all valid flags and the queue
module swept_aabb_collision_time (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // mover_pos_x, mover_pos_y, mover_width, mover_height, mover_vel_x, mover_vel_y,
    // target_pos_x, target_pos_y, target_width, target_height, target_active, frame_time
    input  logic [sacdt_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // hit, hit_time, normal_x, normal_y
    output logic [sacdt_pkg::OUT_W-1:0]   m_axis_tdata
);

    logic            f_valid, f_ready, q_valid, q_ready;
    sacdt_pkg::t_job f_job, q_job;
    logic            hit;
    logic [15:0]     hit_time;
    logic [1:0]      nx, ny;

    sacdt_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_data(s_axis_tdata),
        .o_valid(f_valid), .i_ready(f_ready), .o_job(f_job)
    );

    sacdt_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_job(f_job),
        .o_valid(q_valid), .i_ready(q_ready), .o_job(q_job)
    );

    sacdt_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_job(q_job),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_hit(hit), .o_hit_time(hit_time), .o_normal_x(nx), .o_normal_y(ny)
    );

    assign m_axis_tdata = {3'b000, ny, nx, hit_time, hit};

`ifndef ASSERT_OFF
    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[20:1] == 20'h0)
        else $error("miss result carries nonzero fields");
    a_one_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[18:17] == 2'b00 || m_axis_tdata[20:19] == 2'b00)
        else $error("normal set on both axes");
    a_normal_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[18:17] != 2'b10 && m_axis_tdata[20:19] != 2'b10)
        else $error("normal component out of range");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");
`endif

endmodule

>>> tb/sv/tb_swept_aabb_collision_time.sv
`timescale 1ns / 1ps

module tb_swept_aabb_collision_time;

    localparam longint SHRINK_UNITS = 1311;
    localparam longint UNB = 64'sd1 << 40;
    localparam longint TSAT_MAX = 64'sd2147483647;
    localparam longint TSAT_MIN = -64'sd2147483648;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 750;

    typedef struct packed {
        logic [23:0] frame_time;
        logic        target_active;
        logic [30:0] target_height;
        logic [30:0] target_width;
        logic [31:0] target_pos_y;
        logic [31:0] target_pos_x;
        logic [31:0] mover_vel_y;
        logic [31:0] mover_vel_x;
        logic [30:0] mover_height;
        logic [30:0] mover_width;
        logic [31:0] mover_pos_y;
        logic [31:0] mover_pos_x;
    } t_box_pair;

    typedef struct packed {
        logic [1:0]  normal_y;
        logic [1:0]  normal_x;
        logic [15:0] hit_time;
        logic        hit;
    } t_contact;

    typedef struct {
        t_box_pair pair;
        logic      fixed;
        t_contact  res;
    } t_vector;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [sacdt_pkg::IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [sacdt_pkg::OUT_W-1:0] m_axis_tdata;

    t_contact expected_contacts[$];
    int errors = 0;
    int cycles = 0;
    int hits_seen = 0;
    int items_sent = 0;

    swept_aabb_collision_time dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_swept_aabb_collision_time: done, errors");
            $finish;
        end
    end

    function automatic longint slab_time(longint n, longint d);
        logic neg;
        longint unsigned a, b, q, r;
        int i;
        neg = (n < 0) != (d < 0);
        a = n < 0 ? -n : n;
        b = d < 0 ? -d : d;
        q = a / b;
        r = a % b;
        for (i = 0; i < 31 && q < (64'd1 << 32); i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= b) begin
                r = r - b;
                q = q | 1;
            end
        end
        if (i < 31) return neg ? TSAT_MIN : TSAT_MAX;
        if (neg) return q > (64'd1 << 31) ? TSAT_MIN : -longint'(q);
        return q > TSAT_MAX ? TSAT_MAX : longint'(q);
    endfunction

    function automatic logic slab_span(longint p, longint lo, longint hi, longint d,
                                       output longint t_in, output longint t_out);
        longint ta, tb;
        t_in = 0;
        t_out = 0;
        if (d == 0) begin
            if (p <= lo || p >= hi) return 0;
            t_in = -UNB;
            t_out = UNB;
            return 1;
        end
        ta = slab_time(lo - p, d);
        tb = slab_time(hi - p, d);
        t_in = ta < tb ? ta : tb;
        t_out = ta < tb ? tb : ta;
        return 1;
    endfunction

    function automatic t_contact predict_contact(t_box_pair b);
        t_contact c;
        longint px, py, tx, ty, mw, mh, tw, th, vx, vy, ft;
        longint x1, x2, y1, y2, c1, c2;
        c = '0;
        px = 2 * longint'($signed(b.mover_pos_x));
        py = 2 * longint'($signed(b.mover_pos_y));
        tx = 2 * longint'($signed(b.target_pos_x));
        ty = 2 * longint'($signed(b.target_pos_y));
        vx = longint'($signed(b.mover_vel_x));
        vy = longint'($signed(b.mover_vel_y));
        mw = longint'(b.mover_width);
        mh = longint'(b.mover_height);
        tw = longint'(b.target_width);
        th = longint'(b.target_height);
        ft = longint'(b.frame_time);
        if (!b.target_active) return c;
        if (!slab_span(px, tx - tw - mw + SHRINK_UNITS, tx + tw + mw - SHRINK_UNITS,
                       vx * ft, x1, x2)) return c;
        if (!slab_span(py, ty - th - mh + SHRINK_UNITS, ty + th + mh - SHRINK_UNITS,
                       vy * ft, y1, y2)) return c;
        if (x1 > y2 || y1 > x2) return c;
        c1 = x1 > y1 ? x1 : y1;
        if (c1 < 0 || c1 >= 65536) return c;
        c2 = x2 < y2 ? x2 : y2;
        if (c2 < 0) return c;
        c.hit = 1'b1;
        c.hit_time = c1[15:0];
        if (x1 > y1) c.normal_x = vx < 0 ? 2'sd1 : -2'sd1;
        else if (x1 < y1) c.normal_y = vy < 0 ? 2'sd1 : -2'sd1;
        return c;
    endfunction

    function automatic t_box_pair rand_pair();
        t_box_pair b;
        logic [351:0] raw;
        int mode;
        mode = $urandom_range(0, 9);
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom, $urandom};
        b = raw[$bits(t_box_pair)-1:0];
        if (mode < 7) begin
            // plausible scene: small boxes, mover heading toward target
            b.target_pos_x = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            b.target_pos_y = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            b.target_width = 31'($urandom_range(0, 32'h0010_0000));
            b.target_height = 31'($urandom_range(0, 32'h0010_0000));
            b.mover_width = 31'($urandom_range(0, 32'h0010_0000));
            b.mover_height = 31'($urandom_range(0, 32'h0010_0000));
            b.mover_pos_x = b.target_pos_x + $signed($urandom_range(0, 32'h0040_0000))
                            - 32'sh0020_0000;
            b.mover_pos_y = b.target_pos_y + $signed($urandom_range(0, 32'h0040_0000))
                            - 32'sh0020_0000;
            b.mover_vel_x = (b.target_pos_x - b.mover_pos_x) * $urandom_range(1, 4)
                            + $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            b.mover_vel_y = (b.target_pos_y - b.mover_pos_y) * $urandom_range(1, 4)
                            + $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            if ($urandom_range(0, 9) == 0) b.mover_vel_x = '0;
            if ($urandom_range(0, 9) == 0) b.mover_vel_y = '0;
            b.frame_time = 24'($urandom_range(0, 32'h0002_0000));
            if ($urandom_range(0, 19) == 0) b.frame_time = '0;
            b.target_active = $urandom_range(0, 15) != 0;
        end
        return b;
    endfunction

    // expectation is queued at the accept edge, well ahead of the result
    task automatic send_pair(t_box_pair b, t_contact want_c);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata <= sacdt_pkg::IN_W'(b);
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_contacts.push_back(want_c);
        items_sent++;
    endtask

    always @(posedge i_clk) begin
        t_contact got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[$bits(t_contact)-1:0];
            if (expected_contacts.size() == 0) begin
                $error("result with nothing expected: %h", got);
                errors++;
            end else begin
                want = expected_contacts.pop_front();
                if (got.hit !== want.hit) begin
                    $error("hit expected %0d actual %0d", want.hit, got.hit);
                    errors++;
                end
                if (got.hit_time !== want.hit_time) begin
                    $error("hit_time expected %h actual %h", want.hit_time, got.hit_time);
                    errors++;
                end
                if (got.normal_x !== want.normal_x) begin
                    $error("normal_x expected %b actual %b", want.normal_x, got.normal_x);
                    errors++;
                end
                if (got.normal_y !== want.normal_y) begin
                    $error("normal_y expected %b actual %b", want.normal_y, got.normal_y);
                    errors++;
                end
                if (got.hit) hits_seen++;
            end
        end
    end

    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (cycles % 2000 < 300) begin
                m_axis_tready <= 1'b1;
            end else begin
                stall_left <= $urandom_range(0, 7);
                m_axis_tready <= 1'b0;
            end
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic run_pair(t_box_pair b, logic fixed, t_contact res);
        t_contact p;
        p = predict_contact(b);
        if (fixed && p !== res) begin
            $error("table row disagrees with predictor: %h vs %h", res, p);
            errors++;
        end
        send_pair(b, fixed ? res : p);
    endtask

    function automatic t_box_pair mk(int px, int py, int mw, int mh, int vx, int vy,
                                     int tx, int ty, int tw, int th, bit act, int ft);
        t_box_pair b;
        b.mover_pos_x = px; b.mover_pos_y = py;
        b.mover_width = 31'(mw); b.mover_height = 31'(mh);
        b.mover_vel_x = vx; b.mover_vel_y = vy;
        b.target_pos_x = tx; b.target_pos_y = ty;
        b.target_width = 31'(tw); b.target_height = 31'(th);
        b.target_active = act; b.frame_time = 24'(ft);
        return b;
    endfunction

    localparam int ONE = 32'h0001_0000;
    t_vector table_rows[$];

    initial begin
        t_vector v;
        int k;
        // inactive target misses
        v.pair = mk(0, 0, ONE, ONE, ONE, 0, 0, 0, ONE, ONE, 0, ONE);
        v.fixed = 1; v.res = '0; table_rows.push_back(v);
        // all zero: zero velocity outside inverted slab misses
        v.pair = '0; v.fixed = 1; v.res = '0; table_rows.push_back(v);
        // all ones
        v.pair = '1; v.fixed = 0; table_rows.push_back(v);
        // zero velocity inside both slabs: equal unbounded entries, zero normal
        v.pair = mk(0, 0, ONE, ONE, 0, 0, 0, 0, ONE, ONE, 1, ONE);
        v.fixed = 0; table_rows.push_back(v);
        // zero frame time inside
        v.pair = mk(0, 0, ONE, ONE, ONE, ONE, 0, 0, ONE, ONE, 1, 0);
        table_rows.push_back(v);
        // approach along +x, -x, +y, -y
        v.pair = mk(-4 * ONE, 0, ONE, ONE, 8 * ONE, 0, 0, 0, ONE, ONE, 1, ONE);
        table_rows.push_back(v);
        v.pair = mk(4 * ONE, 0, ONE, ONE, -8 * ONE, 0, 0, 0, ONE, ONE, 1, ONE);
        table_rows.push_back(v);
        v.pair = mk(0, -4 * ONE, ONE, ONE, 0, 8 * ONE, 0, 0, ONE, ONE, 1, ONE);
        table_rows.push_back(v);
        v.pair = mk(0, 4 * ONE, ONE, ONE, 0, -8 * ONE, 0, 0, ONE, ONE, 1, ONE);
        table_rows.push_back(v);
        // diagonal with equal entry times
        v.pair = mk(-4 * ONE, -4 * ONE, ONE, ONE, 8 * ONE, 8 * ONE, 0, 0, ONE, ONE, 1, ONE);
        table_rows.push_back(v);
        // moving away, too slow, already overlapping
        v.pair = mk(-4 * ONE, 0, ONE, ONE, -8 * ONE, 0, 0, 0, ONE, ONE, 1, ONE);
        table_rows.push_back(v);
        v.pair = mk(-40 * ONE, 0, ONE, ONE, ONE, 0, 0, 0, ONE, ONE, 1, ONE);
        table_rows.push_back(v);
        v.pair = mk(0, 0, ONE, ONE, ONE, ONE, 0, 0, ONE, ONE, 1, ONE);
        table_rows.push_back(v);
        // tiny boxes: shrink inverts slab
        v.pair = mk(-4 * ONE, 0, 0, 0, 8 * ONE, 0, 0, 0, 100, 100, 1, ONE);
        table_rows.push_back(v);
        // saturating quotients: extreme positions and velocities
        v.pair = mk(32'h8000_0000, 32'h7FFF_FFFF, 1, 1, 1, -1, 32'h7FFF_FFFF,
                    32'h8000_0000, 1, 1, 1, 32'hFF_FFFF);
        table_rows.push_back(v);
        v.pair = mk(32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    1, 32'hFF_FFFF);
        table_rows.push_back(v);
        v.pair = mk(-2 * ONE, 0, ONE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, ONE,
                    32'h7FFF_FFFF, 1, 1);
        table_rows.push_back(v);

        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[i]) run_pair(table_rows[i].pair, table_rows[i].fixed,
                                         table_rows[i].res);
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 2) begin
                s_axis_tvalid <= 1'b0;
                while (expected_contacts.size() != 0) @(posedge i_clk);
            end
            run_pair(rand_pair(), 0, '0);
        end
        s_axis_tvalid <= 1'b0;
        while (expected_contacts.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("sent %0d box pairs (%0d table rows), %0d hits reported",
                 items_sent, table_rows.size(), hits_seen);
        if (errors == 0 && expected_contacts.size() == 0) begin
            $display("tb_swept_aabb_collision_time: done, clean");
        end else begin
            $display("tb_swept_aabb_collision_time: done, errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/sacdt_pkg.sv
hw/rtl/sacdt_front.sv
hw/rtl/sacdt_fifo.sv
hw/rtl/sacdt_div.sv
hw/rtl/sacdt_back.sv
hw/rtl/swept_aabb_collision_time.sv
tb/sv/tb_swept_aabb_collision_time.sv
